// ===== design/rtlen_pkg.sv =====
// rtlen_pkg: shared widths and types of the route tour length block
// no dependencies; used by the interfaces, the table RAM users and the top level
package rtlen_pkg;

  // node index and table geometry
  localparam int NODE_COUNT = 64;
  localparam int NODE_W     = 6;
  localparam int TAB_DEPTH  = NODE_COUNT * NODE_COUNT;
  localparam int TAB_AW     = 2 * NODE_W;

  // distance and sum widths, unsigned fixed point with 8 fraction bits
  localparam int DIST_IN_W  = 32;
  localparam int DIST_WIDTH = 32;
  localparam int SUM_WIDTH  = 40;
  localparam int ACC_W      = SUM_WIDTH + 2;

  // input beat kinds
  localparam logic FUNC_TAB_WRITE = 1'b0;
  localparam logic FUNC_TOKEN     = 1'b1;

  typedef logic [NODE_W-1:0]     node_t;
  typedef logic [TAB_AW-1:0]     tab_addr_t;
  typedef logic [DIST_WIDTH-1:0] dist_t;
  typedef logic [SUM_WIDTH-1:0]  sum_t;

  localparam sum_t  SUM_MAX = '1;
  localparam node_t DEPOT   = '0;

  // per-token control carried from the read stage to the add stage
  typedef struct packed {
    logic valid;
    logic hop_en;
    logic close_en;
    logic last;
  } tok_ctl_t;

endpackage

// ===== design/rtlen_in_if.sv =====
// rtlen_in_if: input channel of the route tour length block (table writes and tokens)
// depends on rtlen_pkg
interface rtlen_in_if;
  import rtlen_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 func;
  node_t                from_node;
  node_t                to_node;
  logic [DIST_IN_W-1:0] distance;
  node_t                node_id;
  logic                 separator;
  logic                 last_token;

  modport source (
    output valid, func, from_node, to_node, distance, node_id, separator, last_token,
    input  ready
  );

  modport sink (
    input  valid, func, from_node, to_node, distance, node_id, separator, last_token,
    output ready
  );
endinterface

// ===== design/rtlen_out_if.sv =====
// rtlen_out_if: result channel of the route tour length block
// depends on rtlen_pkg
interface rtlen_out_if;
  import rtlen_pkg::*;

  logic valid;
  logic ready;
  sum_t total_distance;
  logic overflow;

  modport source (
    output valid, total_distance, overflow,
    input  ready
  );

  modport sink (
    input  valid, total_distance, overflow,
    output ready
  );
endinterface

// ===== design/rtlen_ram.sv =====
// rtlen_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
module rtlen_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/route_tour_length_core.sv =====
// route_tour_length_core: total distance of a multi-vehicle route
// depends on rtlen_pkg, rtlen_in_if, rtlen_out_if, rtlen_ram
//
// Usage: one input channel (tok) carries two kinds of beat. With func low a
// beat writes one entry of the 64 x 64 distance table (row from_node, column
// to_node). With func high it is a route token: a node visit or a tour
// separator, and last_token ends the route. The result channel (res) gives
// one beat per route: the saturated sum and an overflow flag.
// Throughput: one beat per cycle while not stalled, table writes and tokens
// alike. Each token needs at most one hop read and one depot-return read;
// the table is held in two copies of one RAM so both reads issue in the
// same cycle, and the sum register is updated once per cycle by a
// three-operand add. When a last token is accepted, the RAMs read and its
// control enters the add stage; the sum then lands in the output register,
// unless a stall holds the add stage.
// Stall: while a result waits in the output register the block keeps taking
// beats; it only holds tok.ready low when a second result is ready to leave
// the add stage and the first one has not been taken.
// Reset: clears the route state and empties the pipeline. The table is not
// cleared; every entry a route reads must be written first.
module route_tour_length_core (
  input logic        clk,
  input logic        rst,
  rtlen_in_if.sink   tok,
  rtlen_out_if.source res
);
  import rtlen_pkg::*;

  // route state tracked at accept time
  node_t    prev_node;
  logic     tour_open;

  // add stage
  tok_ctl_t s1;
  sum_t     run_sum;
  logic     sum_sat;

  // output register
  logic     out_valid;
  sum_t     out_sum;
  logic     out_ovf;

  logic      stall;
  logic      accept;
  logic      is_token;
  logic      hop_en;
  logic      close_en;
  node_t     hop_row;
  node_t     close_row;
  tab_addr_t hop_addr;
  tab_addr_t close_addr;
  tab_addr_t wr_addr;
  logic      tab_we;
  dist_t     hop_dist;
  dist_t     close_dist;
  logic [ACC_W-1:0] acc;
  sum_t      sum_next;
  logic      sat_next;

  // stall only when the add stage has a result and the full output is not taken
  assign stall     = s1.valid && s1.last && out_valid && !res.ready;
  assign tok.ready = !stall;
  assign accept    = tok.valid && tok.ready;
  assign is_token  = (tok.func == FUNC_TOKEN);

  // read addresses for the hop and the depot return of this token
  always_comb begin
    hop_en     = is_token && !tok.separator;
    close_en   = is_token && (tok.separator ? tour_open : tok.last_token);
    hop_row    = tour_open ? prev_node : DEPOT;
    close_row  = tok.separator ? prev_node : tok.node_id;
    hop_addr   = {hop_row, tok.node_id};
    close_addr = {close_row, DEPOT};
    wr_addr    = {tok.from_node, tok.to_node};
    tab_we     = accept && (tok.func == FUNC_TAB_WRITE);
  end

  // two copies of the distance table, written together
  rtlen_ram #(.WIDTH(DIST_WIDTH), .DEPTH(TAB_DEPTH)) u_hop_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (wr_addr),
    .wdata (tok.distance[DIST_WIDTH-1:0]),
    .re    (accept),
    .raddr (hop_addr),
    .rdata (hop_dist)
  );

  rtlen_ram #(.WIDTH(DIST_WIDTH), .DEPTH(TAB_DEPTH)) u_close_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (wr_addr),
    .wdata (tok.distance[DIST_WIDTH-1:0]),
    .re    (accept),
    .raddr (close_addr),
    .rdata (close_dist)
  );

  // route state: previous node and open tour flag
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_node <= DEPOT;
      tour_open <= 1'b0;
    end else if (accept && is_token) begin
      if (tok.last_token) begin
        prev_node <= DEPOT;
        tour_open <= 1'b0;
      end else if (tok.separator) begin
        tour_open <= 1'b0;
      end else begin
        prev_node <= tok.node_id;
        tour_open <= 1'b1;
      end
    end
  end

  // token control into the add stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (!stall) begin
      s1.valid    <= accept && is_token;
      s1.hop_en   <= hop_en;
      s1.close_en <= close_en;
      s1.last     <= tok.last_token;
    end
  end

  // saturating add of both distances
  always_comb begin
    acc = ACC_W'(run_sum)
        + (s1.hop_en   ? ACC_W'(hop_dist)   : '0)
        + (s1.close_en ? ACC_W'(close_dist) : '0);
    if (acc > ACC_W'(SUM_MAX)) begin
      sum_next = SUM_MAX;
      sat_next = 1'b1;
    end else begin
      sum_next = acc[SUM_WIDTH-1:0];
      sat_next = sum_sat;
    end
  end

  // running sum, cleared after the last token of a route
  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum <= '0;
      sum_sat <= 1'b0;
    end else if (s1.valid && !stall) begin
      if (s1.last) begin
        run_sum <= '0;
        sum_sat <= 1'b0;
      end else begin
        run_sum <= sum_next;
        sum_sat <= sat_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1.valid && s1.last && !stall) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1.valid && s1.last && !stall) begin
      out_sum <= sum_next;
      out_ovf <= sat_next;
    end
  end

  assign res.valid          = out_valid;
  assign res.total_distance = out_sum;
  assign res.overflow       = out_ovf;

endmodule

// ===== sim/tb_route_tour_length_core.sv =====
// tb_route_tour_length_core: self-checking bench for the route tour length block
// depends on rtlen_pkg, rtlen_in_if, rtlen_out_if and route_tour_length_core
// beats are predicted by a scoreboard class and every route total is checked in order
module tb_route_tour_length_core;
  timeunit 1ns;
  timeprecision 1ps;
  import rtlen_pkg::*;

  localparam int unsigned RANDOM_BEATS = 820;
  localparam int unsigned QUIET_BEATS  = 150;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam node_t       HEAVY_A      = node_t'(62);
  localparam node_t       HEAVY_B      = node_t'(63);

  typedef struct {
    logic                 func;
    node_t                from_node;
    node_t                to_node;
    logic [DIST_IN_W-1:0] distance;
    node_t                node_id;
    logic                 separator;
    logic                 last_token;
  } beat_t;

  typedef struct {
    sum_t total;
    logic ovf;
  } route_total_t;

  // route sum predictor and ordered store of expected route totals
  class route_scoreboard;
    dist_t        dist_tab [TAB_DEPTH];
    sum_t         route_sum = '0;
    node_t        prev_node = DEPOT;
    bit           tour_open = 1'b0;
    bit           saturated = 1'b0;
    route_total_t totals_due [$];
    int unsigned  errors = 0;

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void add_leg(dist_t d);
      logic [SUM_WIDTH:0] wide;
      wide = route_sum + d;
      if (wide > SUM_MAX) begin
        route_sum = SUM_MAX;
        saturated = 1'b1;
      end else begin
        route_sum = wide[SUM_WIDTH-1:0];
      end
    endfunction

    function void close_tour();
      if (tour_open) begin
        add_leg(dist_tab[{prev_node, DEPOT}]);
        tour_open = 1'b0;
      end
    endfunction

    // one accepted input beat
    function void note_beat(beat_t b);
      node_t row;
      if (b.func == FUNC_TAB_WRITE) begin
        dist_tab[{b.from_node, b.to_node}] = b.distance[DIST_WIDTH-1:0];
        return;
      end
      if (b.separator) begin
        close_tour();
      end else begin
        row = tour_open ? prev_node : DEPOT;
        add_leg(dist_tab[{row, b.node_id}]);
        tour_open = 1'b1;
        prev_node = b.node_id;
      end
      if (b.last_token) begin
        close_tour();
        totals_due.push_back('{route_sum, saturated});
        route_sum = '0;
        prev_node = DEPOT;
        tour_open = 1'b0;
        saturated = 1'b0;
      end
    endfunction

    // one accepted result beat
    task check_total(sum_t total, logic ovf);
      route_total_t want;
      if (totals_due.size() == 0) begin
        report($sformatf("route total %0h with none pending", total));
        return;
      end
      want = totals_due.pop_front();
      if (total !== want.total)
        report($sformatf("total_distance %0h, want %0h", total, want.total));
      if (ovf !== want.ovf)
        report($sformatf("overflow %0b, want %0b", ovf, want.ovf));
    endtask

    function int unsigned pending();
      return totals_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  rtlen_in_if  tok_ch();
  rtlen_out_if res_ch();

  route_scoreboard sb = new;

  // stimulus-side view of the route, used to keep every read entry written
  bit          entry_set [TAB_DEPTH];
  node_t       walk_prev;
  bit          walk_open;
  bit          src_idle_en;
  bit          snk_stall_en;
  bit          hold_req;
  int unsigned beats_sent;
  int unsigned cycle_cnt;

  route_tour_length_core u_top (
    .clk (clk),
    .rst (rst),
    .tok (tok_ch),
    .res (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_total(res_ch.total_distance, res_ch.overflow);
  end

  // receiver: random stall bursts plus one long hold-off on request
  initial begin : sink_side
    int unsigned hold_cnt;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
        res_ch.ready <= 1'b1;
      end else if (snk_stall_en && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        res_ch.ready <= 1'b1;
      end
    end
  end

  function automatic dist_t pick_distance();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return dist_t'($urandom);
    endcase
  endfunction

  // all fields random; callers fix the ones that matter
  function automatic beat_t random_beat();
    beat_t b;
    b.func       = 1'($urandom_range(0, 1));
    b.from_node  = node_t'($urandom);
    b.to_node    = node_t'($urandom);
    b.distance   = $urandom;
    b.node_id    = node_t'($urandom);
    b.separator  = 1'($urandom_range(0, 1));
    b.last_token = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // drive one beat, with an optional idle burst in front
  task automatic send_beat(beat_t b);
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      tok_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    tok_ch.valid      <= 1'b1;
    tok_ch.func       <= b.func;
    tok_ch.from_node  <= b.from_node;
    tok_ch.to_node    <= b.to_node;
    tok_ch.distance   <= b.distance;
    tok_ch.node_id    <= b.node_id;
    tok_ch.separator  <= b.separator;
    tok_ch.last_token <= b.last_token;
    @(posedge clk);
    while (!tok_ch.ready) @(posedge clk);
    sb.note_beat(b);
    beats_sent++;
  endtask

  task automatic write_entry(node_t row, node_t col, dist_t d);
    beat_t b;
    b           = random_beat();
    b.func      = FUNC_TAB_WRITE;
    b.from_node = row;
    b.to_node   = col;
    b.distance  = d;
    send_beat(b);
    entry_set[{row, col}] = 1'b1;
  endtask

  task automatic need_entry(node_t row, node_t col);
    if (!entry_set[{row, col}])
      write_entry(row, col, pick_distance());
  endtask

  // node token; the hop entry and the later return entry are written first
  task automatic visit(node_t n, bit last);
    beat_t b;
    need_entry(walk_open ? walk_prev : DEPOT, n);
    need_entry(n, DEPOT);
    b            = random_beat();
    b.func       = FUNC_TOKEN;
    b.node_id    = n;
    b.separator  = 1'b0;
    b.last_token = last;
    send_beat(b);
    walk_open = !last;
    walk_prev = last ? DEPOT : n;
  endtask

  task automatic separate(bit last);
    beat_t b;
    b            = random_beat();
    b.func       = FUNC_TOKEN;
    b.separator  = 1'b1;
    b.last_token = last;
    send_beat(b);
    walk_open = 1'b0;
    if (last)
      walk_prev = DEPOT;
  endtask

  // short route over nodes 0..span, with separators and stray table writes
  task automatic random_route(int unsigned span);
    int unsigned len;
    int unsigned k;
    len = $urandom_range(0, 12);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0)
        write_entry(node_t'($urandom), node_t'($urandom), pick_distance());
      if ($urandom_range(0, 4) == 0)
        separate(1'b0);
      else
        visit(node_t'($urandom_range(0, span)), 1'b0);
    end
    if ($urandom_range(0, 2) == 0)
      separate(1'b1);
    else
      visit(node_t'($urandom_range(0, span)), 1'b1);
  endtask

  // 256 maximal legs end 255 below the sum limit; the return leg lands
  // exactly on the limit, or one past it when spill is set
  task automatic long_route(bit spill);
    dist_t       tail;
    int unsigned k;
    tail = spill ? dist_t'(256) : dist_t'(255);
    write_entry(DEPOT, HEAVY_A, '1);
    write_entry(HEAVY_A, HEAVY_B, '1);
    write_entry(HEAVY_B, HEAVY_A, '1);
    write_entry(HEAVY_A, DEPOT, tail);
    write_entry(HEAVY_B, DEPOT, tail);
    visit(HEAVY_A, 1'b0);
    for (k = 1; k < 256; k++)
      visit(k[0] ? HEAVY_B : HEAVY_A, 1'b0);
    if (spill) begin
      separate(1'b0);
      visit(HEAVY_A, 1'b0);
    end
    separate(1'b1);
  endtask

  initial begin : stimulus
    int unsigned span;
    bit          heavy_fit;
    bit          heavy_spill;
    rst                 = 1'b1;
    tok_ch.valid        = 1'b0;
    tok_ch.func         = FUNC_TAB_WRITE;
    tok_ch.from_node    = '0;
    tok_ch.to_node      = '0;
    tok_ch.distance     = '0;
    tok_ch.node_id      = '0;
    tok_ch.separator    = 1'b0;
    tok_ch.last_token   = 1'b0;
    res_ch.ready        = 1'b1;
    walk_prev           = DEPOT;
    walk_open           = 1'b0;
    src_idle_en         = 1'b1;
    snk_stall_en        = 1'b1;
    hold_req            = 1'b0;
    beats_sent          = 0;
    heavy_fit           = 1'b0;
    heavy_spill         = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed: empty route, stray separators, node zero, extreme distances
    separate(1'b1);
    write_entry(DEPOT, DEPOT, '0);
    write_entry(HEAVY_B, HEAVY_B, '1);
    write_entry(DEPOT, HEAVY_B, dist_t'(32'h8000_0001));
    write_entry(HEAVY_B, DEPOT, dist_t'(32'h0000_0100));
    separate(1'b0);
    separate(1'b0);
    visit(DEPOT, 1'b0);
    visit(HEAVY_B, 1'b0);
    visit(HEAVY_B, 1'b0);
    separate(1'b0);
    separate(1'b0);
    visit(HEAVY_B, 1'b0);
    visit(DEPOT, 1'b1);
    visit(node_t'(5), 1'b1);
    visit(node_t'(5), 1'b0);
    separate(1'b1);

    // random routes, one long receiver hold-off at the start
    beats_sent = 0;
    hold_req   = 1'b1;
    while (beats_sent < RANDOM_BEATS) begin
      if (beats_sent + QUIET_BEATS > RANDOM_BEATS) begin
        src_idle_en  = 1'b0;
        snk_stall_en = 1'b0;
      end
      if (!heavy_fit && beats_sent > 150) begin
        long_route(1'b0);
        heavy_fit = 1'b1;
      end else if (!heavy_spill && beats_sent > 500) begin
        long_route(1'b1);
        heavy_spill = 1'b1;
      end else begin
        span = ($urandom_range(0, 3) == 0) ? 63 : 7;
        random_route(span);
      end
    end
    @(negedge clk);
    tok_ch.valid <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
